// ===== rtl/ckgl_pkg.sv =====
// ----------------------------------------------------------------------------
// ckgl_pkg: shared types and constants
// Token carried down the key cell chain, register indexes, default sizes.
// ----------------------------------------------------------------------------
package ckgl_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int POS_BITS_DEF = 12;

  localparam int POS_W   = 16;
  localparam int TIME_W  = 16;
  localparam int PROD_W  = 32;
  localparam int CH_W    = 8;
  localparam int COLOR_W = 24;
  localparam int NUM_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BAR_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd1;

  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   seg_start;
    logic [POS_W-1:0]   seg_end;
    logic [COLOR_W-1:0] col_a;
    logic [COLOR_W-1:0] col_b;
  } tok_t;

endpackage

// ===== rtl/ckgl_cell.sv =====
// ----------------------------------------------------------------------------
// ckgl_cell: one color key slot
// Holds one key, tests the pair it forms with its right neighbor against the
// passing query token and hands the token on one cell per cycle.
// ----------------------------------------------------------------------------
module ckgl_cell #(
  parameter int IDX      = 0,
  parameter int MAX_KEYS = ckgl_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ckgl_pkg::TIME_W-1:0]   wr_time,
  input  logic [ckgl_pkg::COLOR_W-1:0]  wr_color,
  input  logic [ckgl_pkg::POS_W-1:0]    bar_w,
  input  logic [4:0]                    key_count,
  input  logic [ckgl_pkg::PROD_W-1:0]   nbr_prod,
  input  logic [ckgl_pkg::COLOR_W-1:0]  nbr_color,
  input  ckgl_pkg::tok_t                tok_in,
  output ckgl_pkg::tok_t                tok_out,
  output logic [ckgl_pkg::PROD_W-1:0]   my_prod,
  output logic [ckgl_pkg::COLOR_W-1:0]  my_color
);

  logic [ckgl_pkg::TIME_W-1:0]  time_r;
  logic [ckgl_pkg::COLOR_W-1:0] color_r;
  ckgl_pkg::tok_t               tok_r, tok_nxt;
  logic [ckgl_pkg::PROD_W-1:0]  xs;
  logic                         pair_ok, match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_r  <= wr_time;
      color_r <= wr_color;
    end
  end

  assign my_prod  = ckgl_pkg::PROD_W'(time_r) * ckgl_pkg::PROD_W'(bar_w);
  assign my_color = color_r;
  assign xs       = {tok_in.x, 16'h0000};
  assign pair_ok  = ((IDX + 1) < MAX_KEYS) && ((IDX + 1) < int'(key_count));
  assign match    = tok_in.vld && pair_ok && (my_prod <= xs) && (xs < nbr_prod);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.seg_start = my_prod[31:16];
      tok_nxt.seg_end   = nbr_prod[31:16];
      tok_nxt.col_a     = color_r;
      tok_nxt.col_b     = nbr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.hit       <= tok_nxt.hit;
    tok_r.x         <= tok_nxt.x;
    tok_r.seg_start <= tok_nxt.seg_start;
    tok_r.seg_end   <= tok_nxt.seg_end;
    tok_r.col_a     <= tok_nxt.col_a;
    tok_r.col_b     <= tok_nxt.col_b;
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/ckgl_interp.sv =====
// ----------------------------------------------------------------------------
// ckgl_interp: segment interpolator
// Multiplies each channel delta by the pixel offset, then divides by the
// segment span with three bit-serial restoring dividers (floor semantics).
// ----------------------------------------------------------------------------
module ckgl_interp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ckgl_pkg::tok_t               tok,
  output logic                         done,
  output logic [ckgl_pkg::COLOR_W-1:0] color,
  output logic                         hit
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [4:0]                    cnt_r;
  logic                          done_r, hit_r;
  logic [ckgl_pkg::POS_W-1:0]    dx_r, span_r;
  logic [ckgl_pkg::CH_W-1:0]     cs_r  [3];
  logic [ckgl_pkg::CH_W-1:0]     mag_r [3];
  logic                          neg_r [3];
  logic [ckgl_pkg::NUM_W-1:0]    num_r [3];
  logic [ckgl_pkg::NUM_W-1:0]    quo_r [3];
  logic [ckgl_pkg::POS_W:0]      rem_r [3];
  logic [ckgl_pkg::COLOR_W-1:0]  color_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (tok.vld) begin
        if (!tok.hit || tok.x == tok.seg_start || tok.seg_end <= tok.seg_start) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'(ckgl_pkg::NUM_W - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == ST_FIN) ||
                 (state_r == ST_IDLE && tok.vld && state_nxt == ST_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    logic [ckgl_pkg::POS_W:0]   rsh;
    logic [ckgl_pkg::NUM_W-1:0] adj;
    logic [ckgl_pkg::NUM_W:0]   v;
    case (state_r)
      ST_IDLE: begin
        cnt_r  <= '0;
        hit_r  <= tok.hit;
        dx_r   <= tok.x - tok.seg_start;
        span_r <= tok.seg_end - tok.seg_start;
        color_r <= tok.hit ? tok.col_a : '0;
        for (int c = 0; c < 3; c++) begin
          cs_r[c]  <= tok.col_a[c*8 +: 8];
          neg_r[c] <= tok.col_b[c*8 +: 8] < tok.col_a[c*8 +: 8];
          mag_r[c] <= (tok.col_b[c*8 +: 8] < tok.col_a[c*8 +: 8]) ?
                      tok.col_a[c*8 +: 8] - tok.col_b[c*8 +: 8] :
                      tok.col_b[c*8 +: 8] - tok.col_a[c*8 +: 8];
        end
      end
      ST_MUL: begin
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= ckgl_pkg::NUM_W'(mag_r[c]) * ckgl_pkg::NUM_W'(dx_r);
          rem_r[c] <= '0;
          quo_r[c] <= '0;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        for (int c = 0; c < 3; c++) begin
          rsh = {rem_r[c][ckgl_pkg::POS_W-1:0], num_r[c][ckgl_pkg::NUM_W-1]};
          num_r[c] <= {num_r[c][ckgl_pkg::NUM_W-2:0], 1'b0};
          if (rsh >= {1'b0, span_r}) begin
            rem_r[c] <= rsh - {1'b0, span_r};
            quo_r[c] <= {quo_r[c][ckgl_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem_r[c] <= rsh;
            quo_r[c] <= {quo_r[c][ckgl_pkg::NUM_W-2:0], 1'b0};
          end
        end
      end
      ST_FIN: begin
        for (int c = 0; c < 3; c++) begin
          adj = quo_r[c] + ckgl_pkg::NUM_W'(neg_r[c] && (rem_r[c] != '0));
          if (neg_r[c]) begin
            color_r[c*8 +: 8] <= (adj > ckgl_pkg::NUM_W'(cs_r[c])) ? 8'd0 :
                                 cs_r[c] - adj[7:0];
          end else begin
            v = ckgl_pkg::NUM_W'(cs_r[c]) + {1'b0, adj};
            color_r[c*8 +: 8] <= (v > 25'd255) ? 8'd255 : v[7:0];
          end
        end
      end
      default: cnt_r <= '0;
    endcase
  end

  assign done  = done_r;
  assign color = color_r;
  assign hit   = hit_r;

endmodule

// ===== rtl/color_key_gradient_lookup.sv =====
// ----------------------------------------------------------------------------
// color_key_gradient_lookup: piecewise linear color gradient over a bar
// Row of key cells scanned by a query token, then a serial interpolator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_op selects a key load or a query.
//   A load writes slot in_key_index in the cycle it is taken and gives no
//   result. A query gives one result on the out_ channel with out_hit.
//   Config port (cfg_valid / cfg_ready, always ready): index 0 bar width,
//   index 1 key count; write only while the block is idle.
// Query flow:
//   A query walks the row of MAX_KEYS cells, one cell per cycle, then the
//   interpolator runs its serial divide (skipped when no segment covers
//   the position, the position is the segment start or the span is empty).
//   One query is in flight at a time; in_stall stays high from the query
//   until its result is taken.
// Reset: bar width 256, key count 0, no result pending. Key slots are
//   undefined until loaded.
// Stall: a waiting result holds on the out_ ports until out_stall drops.
// ----------------------------------------------------------------------------
module color_key_gradient_lookup #(
  parameter int MAX_KEYS = ckgl_pkg::MAX_KEYS_DEF,
  parameter int POS_BITS = ckgl_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [3:0]                      in_key_index,
  input  logic [15:0]                     in_key_time,
  input  logic [7:0]                      in_key_red,
  input  logic [7:0]                      in_key_green,
  input  logic [7:0]                      in_key_blue,
  input  logic [11:0]                     in_x_pos,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic                            out_hit,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ckgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [11:0]                     cfg_data
);

  localparam logic [ckgl_pkg::POS_W-1:0] POS_MASK =
    ckgl_pkg::POS_W'((64'd1 << POS_BITS) - 64'd1);

  logic [11:0]                    bar_width_r;
  logic [4:0]                     key_count_r;
  logic                           busy_r, busy_nxt;
  logic                           out_valid_r;
  logic [ckgl_pkg::COLOR_W-1:0]   out_color_r;
  logic                           out_hit_r;
  logic                           in_acc, is_load, is_query;
  logic [ckgl_pkg::POS_W-1:0]     bar_w;
  logic [ckgl_pkg::PROD_W-1:0]    prod_a  [MAX_KEYS];
  logic [ckgl_pkg::COLOR_W-1:0]   color_a [MAX_KEYS];
  ckgl_pkg::tok_t                 tok_a   [MAX_KEYS+1];
  logic                           ip_done, ip_hit;
  logic [ckgl_pkg::COLOR_W-1:0]   ip_color;

  assign in_acc   = in_valid && !in_stall;
  assign is_load  = in_acc && (in_op == ckgl_pkg::OP_LOAD);
  assign is_query = in_acc && (in_op == ckgl_pkg::OP_QUERY);
  assign in_stall = busy_r;
  assign cfg_ready = 1'b1;
  assign bar_w    = ckgl_pkg::POS_W'(bar_width_r) & POS_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_width_r <= 12'd256;
      key_count_r <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ckgl_pkg::REG_BAR_WIDTH: bar_width_r <= cfg_data;
        ckgl_pkg::REG_KEY_COUNT: key_count_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tok_a[0]           = '0;
    tok_a[0].vld       = is_query;
    tok_a[0].x         = ckgl_pkg::POS_W'(in_x_pos) & POS_MASK;
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic [ckgl_pkg::PROD_W-1:0]  nbr_prod;
    logic [ckgl_pkg::COLOR_W-1:0] nbr_color;
    if (i + 1 < MAX_KEYS) begin : g_nbr
      assign nbr_prod  = prod_a[i+1];
      assign nbr_color = color_a[i+1];
    end else begin : g_end
      assign nbr_prod  = '0;
      assign nbr_color = '0;
    end
    ckgl_cell #(.IDX(i), .MAX_KEYS(MAX_KEYS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (is_load && (int'(in_key_index) == i)),
      .wr_time   (in_key_time),
      .wr_color  ({in_key_red, in_key_green, in_key_blue}),
      .bar_w     (bar_w),
      .key_count (key_count_r),
      .nbr_prod  (nbr_prod),
      .nbr_color (nbr_color),
      .tok_in    (tok_a[i]),
      .tok_out   (tok_a[i+1]),
      .my_prod   (prod_a[i]),
      .my_color  (color_a[i])
    );
  end

  ckgl_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .tok   (tok_a[MAX_KEYS]),
    .done  (ip_done),
    .color (ip_color),
    .hit   (ip_hit)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (is_query) busy_nxt = 1'b1;
    else if (out_valid_r && !out_stall) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (ip_done) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (ip_done) begin
      out_color_r <= ip_color;
      out_hit_r   <= ip_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r[23:16];
  assign out_green = out_color_r[15:8];
  assign out_blue  = out_color_r[7:0];
  assign out_hit   = out_hit_r;

endmodule

// ===== rtl/ckgl_checker.sv =====
// ----------------------------------------------------------------------------
// ckgl_checker: port-level checks for color_key_gradient_lookup
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module ckgl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_hit
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_hit))
    else $error("stalled result changed");

  a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("miss result not black");

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op |=> in_stall)
    else $error("no stall after query request");

endmodule

bind color_key_gradient_lookup ckgl_checker u_ckgl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_hit   (out_hit)
);

// ===== dv/color_key_gradient_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// color_key_gradient_lookup_tb: self-checking bench for the gradient lookup
// Loads color key tables, sweeps bar width and key count, and queries pixel
// positions under varying request/stall pressure. A scoreboard computes
// each expected pixel and compares it with every result taken.
// ----------------------------------------------------------------------------
module color_key_gradient_lookup_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_t;

  class gradient_scoreboard;
    logic [15:0] key_time_q[16];
    logic [23:0] key_color_q[16];
    logic [11:0] bar_width;
    logic [4:0]  key_count;
    pixel_t      pixel_q[$];
    int          errors;
    int          queries;
    int          hits;

    function void set_reg(logic [ckgl_pkg::CFG_IDX_W-1:0] idx, logic [11:0] data);
      if (idx == ckgl_pkg::REG_BAR_WIDTH) bar_width = data;
      else if (idx == ckgl_pkg::REG_KEY_COUNT) key_count = data[4:0];
    endfunction

    function int blend(int cs, int ce, longint dx, longint span);
      longint num, q;
      num = longint'(ce - cs) * dx;
      q = num / span;
      if ((num % span) != 0 && num < 0) q = q - 1;
      q = q + cs;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return int'(q);
    endfunction

    function void note_input(logic op, logic [3:0] idx, logic [15:0] t,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [11:0] x);
      pixel_t p;
      int n;
      longint ta, tb, xs, s, e;
      logic [23:0] ca, cb;
      if (op == ckgl_pkg::OP_LOAD) begin
        key_time_q[idx]  = t;
        key_color_q[idx] = {r, g, b};
        return;
      end
      p = '0;
      n = (key_count > 16) ? 16 : int'(key_count);
      xs = longint'(x) << 16;
      for (int i = 0; i + 1 < n; i++) begin
        ta = longint'(key_time_q[i]) * longint'(bar_width);
        tb = longint'(key_time_q[i+1]) * longint'(bar_width);
        if (ta <= xs && xs < tb) begin
          ca = key_color_q[i];
          cb = key_color_q[i+1];
          s = ta >> 16;
          e = tb >> 16;
          p.hit = 1'b1;
          if (longint'(x) == s || e <= s) begin
            {p.red, p.green, p.blue} = ca;
          end else begin
            p.red   = 8'(blend(ca[23:16], cb[23:16], longint'(x) - s, e - s));
            p.green = 8'(blend(ca[15:8], cb[15:8], longint'(x) - s, e - s));
            p.blue  = 8'(blend(ca[7:0], cb[7:0], longint'(x) - s, e - s));
          end
        end
      end
      queries++;
      if (p.hit) hits++;
      pixel_q.push_back(p);
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result r=%0d g=%0d b=%0d hit=%0d",
                                   got.red, got.green, got.blue, got.hit);
        return;
      end
      want = pixel_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp r=%0d g=%0d b=%0d hit=%0d, got r=%0d g=%0d b=%0d hit=%0d",
                   want.red, want.green, want.blue, want.hit,
                   got.red, got.green, got.blue, got.hit);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [3:0]  in_key_index;
  logic [15:0] in_key_time;
  logic [7:0]  in_key_red;
  logic [7:0]  in_key_green;
  logic [7:0]  in_key_blue;
  logic [11:0] in_x_pos;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_hit;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [ckgl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [11:0] cfg_data;

  gradient_scoreboard sb;
  int in_idle_pct;
  int out_stall_pct;
  int items_sent;
  int quiet_cycles;

  color_key_gradient_lookup i_dut (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(posedge clk) begin
    out_stall <= rst_n ? ($urandom_range(99) < out_stall_pct) : 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_red, out_green, out_blue, out_hit});
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", sb.pixel_q.size());
      $display("color_key_gradient_lookup_tb: errors");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [3:0] idx, logic [15:0] t,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [11:0] x);
    bit taken;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_key_index <= idx;
    in_key_time  <= t;
    in_key_red   <= r;
    in_key_green <= g;
    in_key_blue  <= b;
    in_x_pos     <= x;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_input(op, idx, t, r, g, b, x);
    items_sent++;
  endtask

  task automatic load_key(int idx, int t, int r, int g, int b);
    send_request(ckgl_pkg::OP_LOAD, 4'(idx), 16'(t), 8'(r), 8'(g), 8'(b), 12'($urandom));
  endtask

  task automatic query(int x);
    send_request(ckgl_pkg::OP_QUERY, 4'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 12'(x));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ckgl_pkg::CFG_IDX_W-1:0] idx, int data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 12'(data);
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    sb.set_reg(idx, 12'(data));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gradient(int n, bit sorted);
    int t;
    t = 0;
    for (int i = 0; i < n; i++) begin
      if (sorted) begin
        t = (i == 0) ? $urandom_range(0, 4000) : t + $urandom_range(0, 2 * 65535 / n);
        if (t > 65535) t = 65535;
      end else begin
        t = $urandom_range(0, 65535);
      end
      load_key(i, t, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int n, bw, kc;
    sb = new();
    sb.bar_width = 12'd256;
    sb.key_count = 5'd0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = ckgl_pkg::OP_LOAD;
    in_key_index = '0;
    in_key_time = '0;
    in_key_red = '0;
    in_key_green = '0;
    in_key_blue = '0;
    in_x_pos = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no keys: black, miss
    query(0);
    query(4095);
    for (int i = 0; i < 16; i++)
      load_key(i, i * 4369, (i % 2) ? 255 : 0, (i % 3) ? 0 : 255, i * 17);
    drain();
    cfg_write(ckgl_pkg::REG_KEY_COUNT, 1);
    query(10);
    drain();
    cfg_write(ckgl_pkg::REG_KEY_COUNT, 16);
    query(0);
    query(17);
    query(128);
    query(255);
    query(256);
    drain();
    cfg_write(ckgl_pkg::REG_BAR_WIDTH, 4095);
    query(0);
    query(2047);
    query(4094);
    query(4095);
    drain();
    cfg_write(ckgl_pkg::REG_BAR_WIDTH, 1);
    query(0);
    drain();
    cfg_write(ckgl_pkg::REG_BAR_WIDTH, 0);
    query(0);
    drain();
    cfg_write(ckgl_pkg::REG_BAR_WIDTH, 300);
    cfg_write(ckgl_pkg::REG_KEY_COUNT, 31);
    cfg_write(2'd3, 'hfff);
    query(150);
    query(299);
    load_key(15, 65535, 255, 255, 255);
    query(299);
    drain();

    n = 0;
    while (items_sent < 2000) begin
      case (n % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 65; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 65; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      drain();
      case ($urandom_range(0, 4))
        0: bw = 1;
        1: bw = 4095;
        2: bw = $urandom_range(2, 64);
        default: bw = $urandom_range(0, 4095);
      endcase
      kc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      cfg_write(ckgl_pkg::REG_BAR_WIDTH, bw);
      cfg_write(ckgl_pkg::REG_KEY_COUNT, kc);
      if ($urandom_range(0, 9) == 0) cfg_write(2'($urandom_range(2, 3)), $urandom);
      load_gradient(16, $urandom_range(0, 4) != 0);
      for (int q = 0; q < 30; q++) begin
        if ($urandom_range(0, 14) == 0)
          load_key($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(0, 4) == 0)
          query($urandom_range(0, 4095));
        else
          query($urandom_range(0, bw));
      end
      n++;
    end

    drain();
    $display("%0d requests, %0d queries, %0d hits over %0d table settings",
             items_sent, sb.queries, sb.hits, n);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("color_key_gradient_lookup_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pixel_q.size());
      $display("color_key_gradient_lookup_tb: errors");
    end
    $finish;
  end
endmodule
